// File: hdl/deq_pkg.sv
// Package: shared constants, codes and control types of the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 64;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOK  = 3'd0,
    PUSH_FRONT = 3'd1,
    PUSH_BACK  = 3'd2,
    POP_FRONT  = 3'd3,
    POP_BACK   = 3'd4,
    REVERSE    = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } op_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic step;
    logic rd;
    logic load;
  } deq_cmd_t;

endpackage

// File: hdl/deq_if.sv
// Interfaces: input and result channels of the double-ended queue.
`timescale 1ns / 1ps

interface deq_in_if
  import deq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   front_word;
  logic [DATA_W-1:0]   back_word;
  logic [COUNT_W-1:0]  entry_count;
  logic                is_empty;
  logic                is_full;
  logic [STATUS_W-1:0] op_status;

  modport source (output valid, output front_word, output back_word, output entry_count,
                  output is_empty, output is_full, output op_status, input ready);
  modport sink   (input valid, input front_word, input back_word, input entry_count,
                  input is_empty, input is_full, input op_status, output ready);
endinterface

// File: hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/deq_ctrl.sv
// Controller: sequences update, store read and result load for each transaction.
`timescale 1ns / 1ps

module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output deq_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/deq_dpath.sv
// Datapath: ring pointers, count, direction flag, word store and result register.
`timescale 1ns / 1ps

module deq_dpath
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  deq_cmd_t            cmd,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [DATA_W-1:0]   in_push_value,
  output logic [DATA_W-1:0]   out_front_word,
  output logic [DATA_W-1:0]   out_back_word,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic                out_is_empty,
  output logic                out_is_full,
  output logic [STATUS_W-1:0] out_op_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);

  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            rev_r, rev_nxt;
  op_status_t      status_r, status_nxt;

  logic [DATA_W-1:0]   front_r, back_r;
  logic [COUNT_W-1:0]  cnt_out_r;
  logic                empty_out_r, full_out_r;
  logic [STATUS_W-1:0] status_out_r;

  kind_t           kind;
  logic            empty, full, at_low;
  logic [AW-1:0]   head_dec, head_inc, tail_slot, high_slot;
  logic [SW-1:0]   tail_sum, high_sum;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [WORD_WIDTH-1:0] wdata, rd_low, rd_high;
  logic [DATA_W-1:0]     low_w, high_w;
  logic [31:0]     count_wide;

  assign kind  = kind_t'(in_kind);
  assign empty = (count_r == '0);
  assign full  = (count_r == FULL_COUNT);
  assign wdata = in_push_value[WORD_WIDTH-1:0];

  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);

  // slot just past the high end
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

  // slot of the high end
  assign high_sum  = SW'(head_r) + SW'(count_r) - SW'(1);
  assign high_slot = empty ? head_r
                   : (high_sum >= DEPTH_S) ? AW'(high_sum - DEPTH_S) : AW'(high_sum);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = ST_DONE;
    we         = 1'b0;
    waddr      = tail_slot;
    at_low     = 1'b0;
    case (kind)
      PUSH_FRONT, PUSH_BACK: begin
        at_low = (kind == PUSH_FRONT) != rev_r;
        if (full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
          if (at_low) begin
            head_nxt = head_dec;
            waddr    = head_dec;
          end
        end
      end
      POP_FRONT, POP_BACK: begin
        at_low = (kind == POP_FRONT) != rev_r;
        if (empty) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
          if (at_low) begin
            head_nxt = head_inc;
          end
        end
      end
      REVERSE: begin
        if (!empty) begin
          rev_nxt = !rev_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      rev_r    <= 1'b0;
      status_r <= ST_DONE;
    end else if (cmd.step) begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      rev_r    <= rev_nxt;
      status_r <= status_nxt;
    end
  end

  // two copies of the store so both ends can be read together
  deq_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_ram_low (
    .clk   (clk),
    .we    (we && cmd.step),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (head_r),
    .rdata (rd_low)
  );

  deq_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_ram_high (
    .clk   (clk),
    .we    (we && cmd.step),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (high_slot),
    .rdata (rd_high)
  );

  assign low_w      = empty ? '0 : DATA_W'(rd_low);
  assign high_w     = empty ? '0 : DATA_W'(rd_high);
  assign count_wide = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      front_r      <= rev_r ? high_w : low_w;
      back_r       <= rev_r ? low_w : high_w;
      cnt_out_r    <= count_wide[COUNT_W-1:0];
      empty_out_r  <= empty;
      full_out_r   <= full;
      status_out_r <= status_r;
    end
  end

  assign out_front_word  = front_r;
  assign out_back_word   = back_r;
  assign out_entry_count = cnt_out_r;
  assign out_is_empty    = empty_out_r;
  assign out_is_full     = full_out_r;
  assign out_op_status   = status_out_r;

endmodule

// File: hdl/double_ended_queue.sv
// Top level: bounded double-ended queue of words held in a ring store.
`timescale 1ns / 1ps

// Takes one transaction at a time and returns one result for each. A transaction
// runs in steps: update the head, count and direction flag and write a pushed
// word, then the registered read of both ends of the store, then load the result
// register. A held result stalls the load step, and no new transaction is
// accepted until the load is done.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  deq_dpath #(.DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_ch.kind),
    .in_push_value   (in_ch.push_value),
    .out_front_word  (out_ch.front_word),
    .out_back_word   (out_ch.back_word),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full),
    .out_op_status   (out_ch.op_status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("transaction accepted while another is in progress");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_empty) |->
      (out_ch.front_word == '0 && out_ch.back_word == '0))
    else $error("empty result carries non-zero words");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_empty && out_ch.is_full))
    else $error("result both empty and full");

  a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ((out_ch.op_status != ST_PUSH_FULL || out_ch.is_full) &&
       (out_ch.op_status != ST_POP_EMPTY || out_ch.is_empty)))
    else $error("status disagrees with fill flags");

endmodule
